/* hdl/tspra_pkg.sv */
// ----------------------------------------------------------------------------
// tspra_pkg
// Shared types and constants for the PID remap allocator.
// ----------------------------------------------------------------------------
package tspra_pkg;

  localparam int PidW          = 13;
  localparam int PidSpaceDef   = 8192;
  localparam int MapDepthDef   = 64;
  localparam int WordW         = 32;
  localparam logic [PidW-1:0] PidNone = 13'h1fff;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_REUSED     = 3'd1,
    ST_NO_FREE    = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_CLEARED    = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REQ_ALLOC = 1'b0,
    REQ_CLEAR = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_LOOK, S_LOOKW, S_WANT, S_SCAN, S_SCANW, S_COMMIT, S_OUT
  } state_t;

endpackage

/* hdl/tspra_bitmap.sv */
// ----------------------------------------------------------------------------
// tspra_bitmap
// Used-PID bitmap held as 32-bit words in a synchronous memory.
// ----------------------------------------------------------------------------
module tspra_bitmap import tspra_pkg::*; #(
  parameter int NWords = PidSpaceDef / WordW,
  parameter int AddrW  = (NWords > 1) ? $clog2(NWords) : 1
) (
  input  logic             clk,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WordW-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WordW-1:0] wr_data
);

  logic [WordW-1:0] mem [NWords];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/tspra_map_table.sv */
// ----------------------------------------------------------------------------
// tspra_map_table
// Old-to-new PID pair table in a synchronous memory.
// ----------------------------------------------------------------------------
module tspra_map_table import tspra_pkg::*; #(
  parameter int Depth = MapDepthDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic              clk,
  input  logic [AddrW-1:0]  rd_addr,
  output logic [2*PidW-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AddrW-1:0]  wr_addr,
  input  logic [2*PidW-1:0] wr_data
);

  logic [2*PidW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/ts_pid_remap_allocator.sv */
// ----------------------------------------------------------------------------
// ts_pid_remap_allocator
// Output PID allocator with old-to-new remap table for a TS multiplexer.
// ----------------------------------------------------------------------------
// One request at a time. A new request is taken only after the previous result
// has been taken. An allocate request first walks the map table, reading and
// comparing one entry after another. It then checks the wanted PID. If that
// PID is taken, it scans the bitmap from the search start word, one 32-bit word
// after another. It then commits: it reads the picked word and writes it back.
// A request passes the accept state before these steps and the output state
// after them. A clear request walks the bitmap memory one word a cycle. The
// same sweep runs after reset and gives no result. The map table needs no
// clearing: entries at or above the count are never read. The result sits in
// an output register until taken.
module ts_pid_remap_allocator import tspra_pkg::*; #(
  parameter int PID_SPACE = PidSpaceDef,
  parameter int MAP_DEPTH = MapDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[0], old_pid[13:1], requested_pid[26:14], search_start[39:27],
  // repeat_ok[40], zero[47:41]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // new_pid[12:0], status[15:13]
  output logic [15:0] out_tdata
);

  localparam int NWords = PID_SPACE / WordW;
  localparam int WAW    = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int MAW    = $clog2(MAP_DEPTH);
  localparam int CntW   = MAW + 1;
  localparam int BitW   = $clog2(WordW);
  localparam logic [PidW:0] SpaceLim = (PidW+1)'(PID_SPACE);

  state_t state_r, state_nxt;
  logic [PidW-1:0] old_r, want_r, start_r;
  logic [PidW-1:0] old_nxt, want_nxt, start_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic [WAW:0]    wi_r, wi_nxt;
  logic [PidW-1:0] pick_r, pick_nxt;
  logic            ov_r, ov_nxt;
  logic [PidW-1:0] onp_r, onp_nxt;
  status_t         ost_r, ost_nxt;
  // set during the reset sweep, which returns no result
  logic            boot_r;
  logic            want_oor, start_oor;

  logic [WAW-1:0]    bm_ra, bm_wa;
  logic [WordW-1:0]  bm_rd, bm_wd;
  logic              bm_we;
  logic [MAW-1:0]    mt_ra;
  logic [2*PidW-1:0] mt_rd;
  logic              mt_we;

  tspra_bitmap #(.NWords(NWords), .AddrW(WAW)) u_bitmap (
    .clk, .rd_addr(bm_ra), .rd_data(bm_rd),
    .wr_en(bm_we), .wr_addr(bm_wa), .wr_data(bm_wd)
  );

  tspra_map_table #(.Depth(MAP_DEPTH), .AddrW(MAW)) u_map (
    .clk, .rd_addr(mt_ra), .rd_data(mt_rd),
    .wr_en(mt_we), .wr_addr(cnt_r[MAW-1:0]), .wr_data({pick_r, old_r})
  );

  assign want_oor  = {1'b0, want_r} >= SpaceLim;
  assign start_oor = {1'b0, start_r} >= SpaceLim;

  // masked word: free bits at or above the start bit in the first word
  logic [WordW-1:0] free_m;
  logic             hit_any;
  logic [BitW-1:0]  hit_bit;
  logic             first_w;

  always_comb begin
    free_m = ~bm_rd;
    if (first_w) begin
      free_m = free_m & ({WordW{1'b1}} << start_r[BitW-1:0]);
    end
    hit_any = |free_m;
    hit_bit = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (free_m[b]) hit_bit = BitW'(b);
    end
  end

  assign first_w = (wi_r[WAW-1:0] == start_r[BitW +: WAW]) && (wi_r[WAW] == 1'b0)
                   && !start_oor;
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = {ost_r, onp_r};

  always_comb begin
    state_nxt = state_r;
    old_nxt = old_r; want_nxt = want_r; start_nxt = start_r;
    cnt_nxt = cnt_r; idx_nxt = idx_r; wi_nxt = wi_r;
    pick_nxt = pick_r;
    ov_nxt = ov_r; onp_nxt = onp_r; ost_nxt = ost_r;
    bm_ra = '0; bm_we = 1'b0; bm_wa = wi_r[WAW-1:0]; bm_wd = '0;
    mt_ra = idx_r[MAW-1:0]; mt_we = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          old_nxt = in_tdata[13:1];
          want_nxt = in_tdata[26:14];
          start_nxt = in_tdata[39:27];
          idx_nxt = '0;
          wi_nxt = '0;
          if (req_t'(in_tdata[0]) == REQ_CLEAR) begin
            state_nxt = S_CLR;
          end else if (in_tdata[13:1] != PidNone && cnt_r != '0) begin
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_WANT;
          end
        end
      end
      S_CLR: begin
        bm_we = 1'b1;
        wi_nxt = wi_r + 1'b1;
        if (wi_r == (WAW+1)'(NWords - 1)) begin
          cnt_nxt = '0;
          if (boot_r) begin
            state_nxt = S_IDLE;
          end else begin
            onp_nxt = '0; ost_nxt = ST_CLEARED;
            state_nxt = S_OUT;
          end
        end
      end
      S_LOOK: begin
        mt_ra = idx_r[MAW-1:0];
        state_nxt = S_LOOKW;
      end
      S_LOOKW: begin
        if (mt_rd[PidW-1:0] == old_r) begin
          onp_nxt = mt_rd[2*PidW-1:PidW]; ost_nxt = ST_REUSED;
          state_nxt = S_OUT;
        end else if (idx_r + 1'b1 == cnt_r) begin
          state_nxt = S_WANT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_WANT: begin
        // first cycle issues read of wanted word, wi_r[WAW] marks the check
        if (want_oor) begin
          wi_nxt = {1'b0, start_r[BitW +: WAW]};
          state_nxt = S_SCAN;
          if (start_oor) begin
            onp_nxt = '0; ost_nxt = ST_NO_FREE; state_nxt = S_OUT;
          end
        end else if (wi_r[WAW] == 1'b0) begin
          bm_ra = want_r[BitW +: WAW];
          wi_nxt = {1'b1, {WAW{1'b0}}};
        end else begin
          bm_ra = want_r[BitW +: WAW];
          if (!bm_rd[want_r[BitW-1:0]]) begin
            pick_nxt = want_r;
            state_nxt = S_COMMIT;
            wi_nxt = '0;
          end else if (start_oor) begin
            onp_nxt = '0; ost_nxt = ST_NO_FREE; state_nxt = S_OUT;
          end else begin
            wi_nxt = {1'b0, start_r[BitW +: WAW]};
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        bm_ra = wi_r[WAW-1:0];
        state_nxt = S_SCANW;
      end
      S_SCANW: begin
        if (hit_any) begin
          pick_nxt = PidW'({wi_r[WAW-1:0], hit_bit});
          state_nxt = S_COMMIT;
        end else if (wi_r == (WAW+1)'(NWords - 1)) begin
          onp_nxt = '0; ost_nxt = ST_NO_FREE; state_nxt = S_OUT;
        end else begin
          wi_nxt = wi_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_COMMIT: begin
        // wi_r[WAW] low: read the picked word; high: write it back
        bm_ra = pick_r[BitW +: WAW];
        bm_wa = pick_r[BitW +: WAW];
        if (cnt_r == CntW'(MAP_DEPTH)) begin
          onp_nxt = '0; ost_nxt = ST_TABLE_FULL; state_nxt = S_OUT;
        end else if (wi_r[WAW] == 1'b0) begin
          wi_nxt = {1'b1, {WAW{1'b0}}};
        end else begin
          bm_we = 1'b1;
          bm_wd = bm_rd | (WordW'(1) << pick_r[BitW-1:0]);
          mt_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          onp_nxt = pick_r; ost_nxt = ST_NEW; state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r <= '0;
      wi_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      wi_r <= wi_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    old_r <= old_nxt; want_r <= want_nxt; start_r <= start_nxt;
    idx_r <= idx_nxt; pick_r <= pick_nxt;
    onp_r <= onp_nxt; ost_r <= ost_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) boot_r <= 1'b1;
    else if (state_r == S_CLR && wi_r == (WAW+1)'(NWords - 1)) boot_r <= 1'b0;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAP_DEPTH)) else $error("map count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("accept while result pending");

endmodule

/* tb/ts_pid_remap_allocator_tb.sv */
// ----------------------------------------------------------------------------
// ts_pid_remap_allocator_tb
// Self-checking bench for the PID remap allocator: a predictor tracks the used
// bitmap and the old-to-new table, and every result is checked in order.
// ----------------------------------------------------------------------------
module ts_pid_remap_allocator_tb;
  import tspra_pkg::*;

  localparam int PidSpace  = PidSpaceDef;
  localparam int MapDepth  = MapDepthDef;
  localparam int IdleLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // req_type[0], old_pid[13:1], requested_pid[26:14], search_start[39:27],
  // repeat_ok[40], zero[47:41]
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // new_pid[12:0], status[15:13]
  logic [15:0] out_tdata;

  // predictor state
  bit              pid_used [PidSpace];
  logic [PidW-1:0] tbl_old [MapDepth];
  logic [PidW-1:0] tbl_new [MapDepth];
  int              tbl_count;

  logic [15:0] pending_results [$];
  int          errors;
  int          n_reqs;
  int          n_status [5];
  int          stall_cycles;
  bit          no_idle;

  ts_pid_remap_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void wipe_tables();
    foreach (pid_used[i]) pid_used[i] = 1'b0;
    tbl_count = 0;
  endfunction

  function automatic logic [15:0] predict_alloc(logic [47:0] d);
    req_t            kind;
    logic [PidW-1:0] old_pid;
    logic [PidW-1:0] want;
    logic [PidW-1:0] start;
    int              pick;
    kind    = req_t'(d[0]);
    old_pid = d[13:1];
    want    = d[26:14];
    start   = d[39:27];
    if (kind == REQ_CLEAR) begin
      wipe_tables();
      return {ST_CLEARED, 13'd0};
    end
    if (old_pid != PidNone) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_old[i] == old_pid) return {ST_REUSED, tbl_new[i]};
      end
    end
    pick = -1;
    if (int'(want) < PidSpace && !pid_used[want]) begin
      pick = want;
    end else begin
      for (int i = start; i < PidSpace; i++) begin
        if (!pid_used[i]) begin
          pick = i;
          break;
        end
      end
    end
    if (pick < 0) return {ST_NO_FREE, 13'd0};
    if (tbl_count >= MapDepth) return {ST_TABLE_FULL, 13'd0};
    pid_used[pick]     = 1'b1;
    tbl_old[tbl_count] = old_pid;
    tbl_new[tbl_count] = pick[PidW-1:0];
    tbl_count++;
    return {ST_NEW, pick[PidW-1:0]};
  endfunction

  task automatic send_req(req_t kind, logic [PidW-1:0] old_pid, logic [PidW-1:0] want,
                          logic [PidW-1:0] start, logic rep);
    logic [47:0] d;
    d = {7'd0, rep, start, want, old_pid, kind};
    if (!no_idle && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 19) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_alloc(d));
    n_reqs++;
  endtask

  task automatic alloc(logic [PidW-1:0] old_pid, logic [PidW-1:0] want,
                       logic [PidW-1:0] start);
    send_req(REQ_ALLOC, old_pid, want, start, 1'($urandom_range(1)));
  endtask

  task automatic clear_all();
    send_req(REQ_CLEAR, 13'($urandom), 13'($urandom), 13'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker and stall watchdog
  always @(posedge clk) begin
    logic [15:0] exp_r;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_tdata[12:0] !== exp_r[12:0]) begin
            $error("new_pid expected %0d actual %0d", exp_r[12:0], out_tdata[12:0]);
            errors++;
          end
          if (out_tdata[15:13] !== exp_r[15:13]) begin
            $error("status expected %0d actual %0d", exp_r[15:13], out_tdata[15:13]);
            errors++;
          end
          if (exp_r[15:13] <= 3'd4) n_status[exp_r[15:13]]++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 19);
  end

  task automatic test_basic_alloc();
    clear_all();
    alloc(13'd100, 13'd200, 13'd0);        // wanted pid free
    alloc(13'd101, 13'd200, 13'd0);        // wanted taken, scan from zero
    alloc(13'd100, 13'd300, 13'd0);        // lookup hit
    alloc(PidNone, 13'd200, 13'd200);      // none never matches
    alloc(PidNone, 13'd200, 13'd5000);
    alloc(13'd0, 13'd0, 13'd0);
    alloc(13'd0, 13'd1, 13'd1);            // hit on old pid zero
    alloc(13'd8190, 13'd8191, 13'd8191);   // top of space
  endtask

  task automatic test_search_edge();
    // 8191 is taken, so a scan from the top finds nothing
    alloc(13'd50, 13'd8191, 13'd8191);
    alloc(13'd51, 13'd8190, 13'd8191);
    alloc(13'd52, 13'd0, 13'd8190);
    alloc(13'd53, 13'd8191, 13'd8190);
  endtask

  task automatic test_table_full();
    clear_all();
    for (int i = 0; i < MapDepth; i++) alloc(13'(i + 1000), 13'(i + 8128), 13'd0);
    alloc(13'd3000, 13'd10, 13'd0);        // table full
    alloc(13'd1005, 13'd10, 13'd0);        // hit still works when full
    alloc(13'd3001, 13'd8191, 13'd8191);   // no free wins over full
    alloc(PidNone, 13'd8191, 13'd8191);
  endtask

  task automatic test_pause_until_done();
    drain();
    clear_all();
    alloc(13'd7, 13'd7, 13'd7);
    drain();
  endtask

  task automatic test_random(int count);
    logic [PidW-1:0] old_pid;
    logic [PidW-1:0] want;
    logic [PidW-1:0] start;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= 200 && n < 320);
      if ($urandom_range(79) == 0) begin
        clear_all();
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: old_pid = 13'($urandom_range(15));
          6:                old_pid = PidNone;
          default:          old_pid = 13'($urandom);
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3: want = 13'($urandom_range(31));
          4, 5:       want = 13'($urandom_range(8191, 8176));
          default:    want = 13'($urandom);
        endcase
        case ($urandom_range(9))
          0, 1, 2: start = 13'($urandom_range(31));
          3, 4, 5: start = 13'($urandom_range(8191, 8176));
          default: start = 13'($urandom);
        endcase
        alloc(old_pid, want, start);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    errors     = 0;
    n_reqs     = 0;
    no_idle    = 1'b0;
    stall_cycles = 0;
    foreach (n_status[i]) n_status[i] = 0;
    wipe_tables();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_alloc();
    test_search_edge();
    test_table_full();
    test_pause_until_done();
    test_random(600);
    drain();
    repeat (400) @(posedge clk);
    $display("%0d requests: %0d new, %0d reused, %0d no free, %0d table full, %0d clears",
             n_reqs, n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
